### design/kwi_pkg.sv
// shared types and constants for the keyframe weight interpolator
// no dependencies
package kwi_pkg;
  localparam int unsigned MaxKeysDefault    = 64;
  localparam int unsigned MaxWeightsDefault = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned KeySlotW = 6;
  localparam int unsigned WSlotW   = 4;
  localparam int unsigned KeysCfgW = 7;
  localparam int unsigned WCfgW    = 5;
  localparam int unsigned FracW    = 16;

  typedef enum logic [1:0] {
    OP_WR_TIME   = 2'd0,
    OP_WR_WEIGHT = 2'd1,
    OP_QUERY     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  localparam logic CFG_KEYS    = 1'b0;
  localparam logic CFG_WEIGHTS = 1'b1;

  typedef struct packed {
    op_e                 op;
    logic [KeySlotW-1:0] key_slot;
    logic [WSlotW-1:0]   weight_slot;
    logic [TimeW-1:0]    time_value;
    logic [WeightW-1:0]  weight_in;
  } item_t;
endpackage

### design/kwi_fifo.sv
// two-entry item queue between the front end and the back end
// depends on kwi_pkg
module kwi_fifo import kwi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

### design/kwi_front.sv
// front end: accepts items, drops op 3 and out-of-range writes
// depends on kwi_pkg and kwi_fifo
module kwi_front import kwi_pkg::*; #(
  parameter int unsigned MaxKeys    = MaxKeysDefault,
  parameter int unsigned MaxWeights = MaxWeightsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);
  logic full, keep;
  always_comb begin
    unique case (item_i.op)
      OP_WR_TIME:   keep = 32'(item_i.key_slot) < MaxKeys;
      OP_WR_WEIGHT: keep = 32'(item_i.key_slot) < MaxKeys
                           && 32'(item_i.weight_slot) < MaxWeights;
      OP_QUERY:     keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end
  assign ready_o = !full;
  kwi_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(valid_i && !full && keep), .data_i(item_i),
    .full_o(full), .pop_i, .data_o(item_o), .empty_o
  );
endmodule

### design/kwi_back.sv
// back end: key memories, key search, serial divider and per-weight lerp
// depends on kwi_pkg
module kwi_back import kwi_pkg::*; #(
  parameter int unsigned MaxKeys    = MaxKeysDefault,
  parameter int unsigned MaxWeights = MaxWeightsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KeysCfgW-1:0] keys_cfg_i,
  input  logic [WCfgW-1:0]    wts_cfg_i,
  input  logic                empty_i,
  input  item_t               item_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [WSlotW-1:0]   num_o,
  output logic [WeightW-1:0]  weight_o,
  output logic                last_o
);
  localparam int unsigned KW = $clog2(MaxKeys);
  localparam int unsigned WW = (MaxWeights > 1) ? $clog2(MaxWeights) : 1;
  localparam int unsigned KC = KW + 1;
  localparam int unsigned WC = WW + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_SRD = 4'd1, S_SCMP = 4'd2, S_T0 = 4'd3,
                         S_DIV = 4'd4, S_RD = 4'd5, S_RD2 = 4'd6, S_MUL = 4'd7,
                         S_ADD = 4'd8, S_OUT = 4'd9;
  logic [3:0] st_q, st_d;

  logic [TimeW-1:0]   times_mem [MaxKeys];
  logic [WeightW-1:0] wts_mem   [MaxKeys*MaxWeights];
  logic [TimeW-1:0]   trd_q;
  logic [WeightW-1:0] wrd_q;
  logic [KW-1:0]      traddr;
  logic [KW+WW-1:0]   wraddr;

  logic [KC-1:0]  nk;
  logic [WC-1:0]  nw;
  logic [TimeW-1:0] t_q, t1_q;
  logic [KC-1:0]  i_q;
  logic [KW-1:0]  k0_q, k1_q;
  logic           same_q;
  logic [WW-1:0]  j_q;
  logic [TimeW:0] rem_q;
  logic [TimeW-1:0] den_q;
  logic [FracW-1:0] f_q;
  logic [4:0]     bit_q;
  logic signed [WeightW-1:0] w0_q;
  logic signed [WeightW:0]   diff_q;
  logic signed [WeightW+FracW+1:0] prod_q;
  logic [WSlotW-1:0] num_q;
  logic last_q;

  always_comb begin
    if (keys_cfg_i == '0) nk = KC'(1);
    else if (32'(keys_cfg_i) > MaxKeys) nk = KC'(MaxKeys);
    else nk = KC'(keys_cfg_i);
    if (wts_cfg_i == '0) nw = WC'(1);
    else if (32'(wts_cfg_i) > MaxWeights) nw = WC'(MaxWeights);
    else nw = WC'(wts_cfg_i);
  end

  wire wr_t = st_q == S_IDLE && !empty_i && item_i.op == OP_WR_TIME;
  wire wr_w = st_q == S_IDLE && !empty_i && item_i.op == OP_WR_WEIGHT;
  wire [KW+WW-1:0] wwaddr = KW'(item_i.key_slot) * (KW+WW)'(MaxWeights)
                            + (KW+WW)'(item_i.weight_slot);

  always_ff @(posedge clk_i) begin
    if (wr_t) times_mem[KW'(item_i.key_slot)] <= item_i.time_value;
    trd_q <= times_mem[traddr];
  end
  always_ff @(posedge clk_i) begin
    if (wr_w) wts_mem[wwaddr] <= item_i.weight_in;
    wrd_q <= wts_mem[wraddr];
  end

  // on a hit the lower key time is fetched for the factor
  always_comb begin
    if (st_q == S_IDLE) traddr = KW'(1);
    else if (st_q == S_SCMP && t_q < trd_q) traddr = KW'(i_q);
    else if (32'(i_q) + 2 < 32'(nk)) traddr = KW'(i_q + KC'(2));
    else traddr = KW'(i_q + KC'(1));
    wraddr = ((st_q == S_RD) ? k0_q : k1_q) * (KW+WW)'(MaxWeights) + (KW+WW)'(j_q);
  end

  wire [TimeW:0] rsh = {rem_q[TimeW-1:0], 1'b0};
  wire           ge  = rsh >= {1'b0, den_q};
  wire signed [WeightW+FracW+1:0] pr = prod_q + (WeightW+FracW+2)'(32768);

  assign pop_o = st_q == S_IDLE && !empty_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (!empty_i && item_i.op == OP_QUERY)
                st_d = (nk > KC'(1)) ? S_SCMP : S_RD;
      S_SRD:  st_d = S_SCMP;
      S_SCMP: if (t_q < trd_q) st_d = S_T0;
              else if (32'(i_q) + 2 >= 32'(nk)) st_d = S_RD;
              else st_d = S_SCMP;
      S_T0:   st_d = S_DIV;
      S_DIV:  if (bit_q == 5'd0) st_d = S_RD;
      S_RD:   st_d = S_RD2;
      S_RD2:  st_d = S_MUL;
      S_MUL:  st_d = S_ADD;
      S_ADD:  st_d = S_OUT;
      S_OUT:  if (ready_i) st_d = last_q ? S_IDLE : S_RD;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        t_q <= item_i.time_value; i_q <= '0; j_q <= '0; f_q <= '0;
        k0_q <= '0; k1_q <= '0; same_q <= 1'b1;
      end
      S_SCMP: begin
        if (t_q < trd_q) begin
          k0_q <= KW'(i_q); k1_q <= KW'(i_q + KC'(1)); same_q <= 1'b0;
          t1_q <= trd_q;
        end else if (32'(i_q) + 2 >= 32'(nk)) begin
          k0_q <= KW'(nk - KC'(1)); k1_q <= KW'(nk - KC'(1));
        end else i_q <= i_q + KC'(1);
      end
      S_T0: begin
        f_q <= '0;
        if (t_q >= trd_q) begin
          den_q <= t1_q - trd_q; rem_q <= {1'b0, t_q - trd_q}; bit_q <= 5'd16;
        end else begin
          den_q <= 32'd1; rem_q <= '0; bit_q <= 5'd0;
        end
      end
      S_DIV: begin
        if (bit_q != 5'd0) begin
          f_q <= {f_q[FracW-2:0], ge};
          rem_q <= ge ? rsh - {1'b0, den_q} : rsh;
          bit_q <= bit_q - 5'd1;
        end
      end
      S_RD2: w0_q <= wrd_q;
      S_MUL: begin
        diff_q <= $signed({wrd_q[WeightW-1], wrd_q}) - $signed({w0_q[WeightW-1], w0_q});
      end
      S_ADD: begin
        prod_q <= diff_q * $signed({1'b0, f_q});
        num_q <= WSlotW'(j_q); last_q <= (32'(j_q) + 1 == 32'(nw));
      end
      S_OUT: if (ready_i) j_q <= j_q + WW'(1);
      default: ;
    endcase
  end

  // output sum from the registered product, steady while the out state waits
  logic [WeightW-1:0] fin;
  assign fin = same_q ? w0_q : WeightW'(w0_q + WeightW'(pr >>> FracW));

  assign valid_o  = st_q == S_OUT;
  assign weight_o = fin;
  assign num_o    = num_q;
  assign last_o   = last_q;
endmodule

### design/keyframe_weight_interpolator_core.sv
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tuser: op; tdata: key_slot, weight_slot, time_value,
//                                   weight_in
// m_axis    out  tvalid/tready      tdata: weight_number, weight_out; tlast: last_weight
// cfg       in   cfg_valid/ready    cfg_index, cfg_data
// a write leaves the queue once the back end is idle; a query takes an idle state, one
// compare per key searched, a serial division when a key pair brackets the time (a zero
// factor when it lies before that pair), then per weight: two reads, subtract, multiply,
// output
// rst_ni clears control and config only; key memories hold garbage until written
// output stalls hold the back end; the two-entry queue keeps taking items until full
module keyframe_weight_interpolator_core import kwi_pkg::*; #(
  parameter int unsigned MaxKeys    = MaxKeysDefault,
  parameter int unsigned MaxWeights = MaxWeightsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // op
  input  logic [63:0] s_axis_tdata,  // key_slot, weight_slot, time_value, weight_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // weight_number, weight_out
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  logic [KeysCfgW-1:0] keys_q;
  logic [WCfgW-1:0]    wts_q;
  item_t in_item, q_item;
  logic  pop, empty;
  logic [WSlotW-1:0]  num;
  logic [WeightW-1:0] wout;

  assign in_item.op          = op_e'(s_axis_tuser);
  assign in_item.key_slot    = s_axis_tdata[5:0];
  assign in_item.weight_slot = s_axis_tdata[9:6];
  assign in_item.time_value  = s_axis_tdata[41:10];
  assign in_item.weight_in   = s_axis_tdata[57:42];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= KeysCfgW'(1); wts_q <= WCfgW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_KEYS) keys_q <= cfg_data_i[KeysCfgW-1:0];
      else wts_q <= cfg_data_i[WCfgW-1:0];
    end
  end

  kwi_front #(.MaxKeys(MaxKeys), .MaxWeights(MaxWeights)) u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .item_i(in_item), .pop_i(pop), .item_o(q_item), .empty_o(empty)
  );
  kwi_back #(.MaxKeys(MaxKeys), .MaxWeights(MaxWeights)) u_back (
    .clk_i, .rst_ni, .keys_cfg_i(keys_q), .wts_cfg_i(wts_q), .empty_i(empty),
    .item_i(q_item), .pop_o(pop), .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .num_o(num), .weight_o(wout), .last_o(m_axis_tlast)
  );
  assign m_axis_tdata = {4'd0, wout, num};

`ifndef NO_ASSERTIONS
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg not ready");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped under stall");
`endif
endmodule
